// ----- rtl/bgr_pkg.sv -----
// Shared types and constants for the button gesture recognizer.
`timescale 1ns / 1ps

package bgr_pkg;

	// Switch state held in one history entry
	typedef enum logic [1:0] {
		SW_OPEN  = 2'd0,
		SW_POWER = 2'd1,
		SW_USER  = 2'd2
	} sw_t;

	// Per-cycle command to the row of history cells
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_SHIFT  = 2'd1,
		CELL_ROTATE = 2'd2,
		CELL_CLEAR  = 2'd3
	} cell_op_t;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	// Taps that the controller reads from the row
	typedef struct packed {
		sw_t  newest;      // entry 0
		logic first_open;  // entries 0..3 all open
		sw_t  prev;        // entry 3
		sw_t  cur;         // entry 4
		sw_t  at_check;    // entry at the release check position
	} chain_taps_t;

	// Field widths
	localparam int unsigned EVENT_W = 4;
	localparam int unsigned TICKS_W = 6;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned HOLD_W  = 7;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 6;
	localparam int unsigned CLICK_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERY_LONG_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_POS       = 2'd2;

	// Configuration reset values
	localparam logic [TICKS_W-1:0] LONG_TICKS_RST      = 6'd10;
	localparam logic [TICKS_W-1:0] VERY_LONG_TICKS_RST = 6'd30;
	localparam logic [POS_W-1:0]   CHECK_POS_RST       = 5'd8;

	// Hold counter limits
	localparam logic [HOLD_W-1:0] HOLD_MAX = 7'd127;
	localparam logic [HOLD_W-1:0] HOLD_RST = 7'd31;

	// Event codes (power switch); user events add EV_USER_OFS
	localparam logic [EVENT_W-1:0] EV_NONE      = 4'd0;
	localparam logic [EVENT_W-1:0] EV_LONG      = 4'd4;
	localparam logic [EVENT_W-1:0] EV_VERY_LONG = 4'd5;
	localparam logic [EVENT_W-1:0] EV_USER_OFS  = 4'd5;
	localparam logic [EVENT_W-1:0] EV_MAX       = 4'd10;

	// Click count that no longer maps to an event
	localparam logic [CLICK_W-1:0] CLICK_SAT = 3'd4;

	// Number of newest entries that must be open before counting
	localparam int unsigned QUIET_ENTRIES = 4;

endpackage

// ----- rtl/bgr_in_if.sv -----
// Input channel: one sample tick or rearm word per transfer.
`timescale 1ns / 1ps

interface bgr_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic power_switch_level;
	logic user_switch_level;

	modport source (output valid, output operation, output power_switch_level,
		output user_switch_level, input ready);
	modport sink (input valid, input operation, input power_switch_level,
		input user_switch_level, output ready);
endinterface

// ----- rtl/bgr_out_if.sv -----
// Output channel: one gesture event word per transfer.
`timescale 1ns / 1ps

interface bgr_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] gesture_event;

	modport source (output valid, output gesture_event, input ready);
	modport sink (input valid, input gesture_event, output ready);
endinterface

// ----- rtl/bgr_cell.sv -----
// One history cell: holds a switch state and passes it to a neighbor.
`timescale 1ns / 1ps

module bgr_cell
	import bgr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  sw_t      from_lo,
	input  sw_t      from_hi,
	output sw_t      entry
);

	sw_t entry_q;

	// Shift toward older entries, rotate toward newer, or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= SW_OPEN;
		end else begin
			unique case (op)
				CELL_HOLD:   entry_q <= entry_q;
				CELL_SHIFT:  entry_q <= from_lo;
				CELL_ROTATE: entry_q <= from_hi;
				CELL_CLEAR:  entry_q <= SW_OPEN;
				default:     entry_q <= entry_q;
			endcase
		end
	end

	assign entry = entry_q;

endmodule

// ----- rtl/bgr_chain.sv -----
// Row of history cells with the fixed taps the controller reads.
`timescale 1ns / 1ps

module bgr_chain
	import bgr_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_op_t          op,
	input  sw_t               shift_in,
	input  logic [POS_W-1:0]  check_pos,
	output chain_taps_t       taps
);

	sw_t entries [HISTORY_DEPTH];

	// Cell row: entry 0 is newest; rotation moves entries toward 0 and wraps
	for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
		bgr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op),
			.from_lo ((g == 0) ? shift_in : entries[(g + HISTORY_DEPTH - 1) % HISTORY_DEPTH]),
			.from_hi (entries[(g + 1) % HISTORY_DEPTH]),
			.entry   (entries[g])
		);
	end

	// Entry at the check position; positions past the row read open
	sw_t at_sel;
	always_comb begin
		at_sel = SW_OPEN;
		for (int j = 0; j < HISTORY_DEPTH; j++) begin
			if (32'(check_pos) == j) at_sel = entries[j];
		end
	end

	// Newest entries all open
	logic quiet;
	always_comb begin
		quiet = 1'b1;
		for (int j = 0; j < QUIET_ENTRIES; j++) begin
			if (entries[j] != SW_OPEN) quiet = 1'b0;
		end
	end

	assign taps.newest     = entries[0];
	assign taps.first_open = quiet;
	assign taps.prev       = entries[QUIET_ENTRIES-1];
	assign taps.cur        = entries[QUIET_ENTRIES];
	assign taps.at_check   = at_sel;

endmodule

// ----- rtl/button_gesture_recognizer_top.sv -----
// Top level: two-switch click and long-press recognizer.
//
//  channel  | dir | fields                                           | flow
//  din      | in  | operation, power_switch_level, user_switch_level | valid/ready
//  dout     | out | gesture_event                                    | valid/ready
//  cfg      | in  | cfg_we, cfg_idx, cfg_data                        | write only
//
// Rearm words, pressed ticks and open ticks with nothing to count finish in
// the accept cycle. An open tick that starts click counting runs one full
// rotation of the cell row in the scan state, then writes back in the done
// state. Reset clears the history and restores the register defaults.
// A stalled output word holds the sequencer in its last state; din is taken
// whenever the sequencer is idle and the output register is free or draining.
`timescale 1ns / 1ps

module button_gesture_recognizer_top
	import bgr_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bgr_in_if.sink                din,
	bgr_out_if.source             dout,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned CNT_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned LAST_PAIR = HISTORY_DEPTH - QUIET_ENTRIES - 1;

	// Configuration registers
	logic [TICKS_W-1:0] long_ticks_q;
	logic [TICKS_W-1:0] very_long_ticks_q;
	logic [POS_W-1:0]   check_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q      <= LONG_TICKS_RST;
			very_long_ticks_q <= VERY_LONG_TICKS_RST;
			check_pos_q       <= CHECK_POS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LONG_TICKS:      long_ticks_q      <= cfg_data[TICKS_W-1:0];
				CFG_VERY_LONG_TICKS: very_long_ticks_q <= cfg_data[TICKS_W-1:0];
				CFG_CHECK_POS:       check_pos_q       <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// History row
	cell_op_t    chain_op;
	sw_t         chain_in;
	chain_taps_t taps;

	bgr_chain #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (chain_op),
		.shift_in  (chain_in),
		.check_pos (check_pos_q),
		.taps      (taps)
	);

	// Sequencer and scan registers
	state_t             state_q, state_d;
	logic [HOLD_W-1:0]  hold_q, hold_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               armed_q, armed_d;
	logic [CLICK_W-1:0] clicks_q, clicks_d;
	sw_t                which_q, which_d;
	logic               out_valid_q, out_valid_d;
	logic [EVENT_W-1:0] out_event_q, out_event_d;

	logic out_free;
	logic in_acc;
	sw_t  s;
	logic [HOLD_W-1:0]  hold_inc;
	logic [EVENT_W-1:0] base;

	assign out_free = !out_valid_q || dout.ready;
	assign din.ready = (state_q == ST_IDLE) && out_free;
	assign in_acc = din.valid && din.ready;

	// Sampled switch state, power first
	always_comb begin
		if (!din.power_switch_level)     s = SW_POWER;
		else if (!din.user_switch_level) s = SW_USER;
		else                             s = SW_OPEN;
	end

	assign hold_inc = (hold_q < HOLD_MAX) ? hold_q + 7'd1 : hold_q;
	assign base = (s == SW_USER) ? EV_USER_OFS : EV_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hold_q      <= HOLD_RST;
			cnt_q       <= '0;
			armed_q     <= 1'b0;
			clicks_q    <= '0;
			which_q     <= SW_OPEN;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			hold_q      <= hold_d;
			cnt_q       <= cnt_d;
			armed_q     <= armed_d;
			clicks_q    <= clicks_d;
			which_q     <= which_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_event_q <= out_event_d;
	end

	// Next state, row commands and result word
	always_comb begin
		state_d     = state_q;
		hold_d      = hold_q;
		cnt_d       = cnt_q;
		armed_d     = armed_q;
		clicks_d    = clicks_q;
		which_d     = which_q;
		out_valid_d = out_valid_q && !dout.ready;
		out_event_d = out_event_q;
		chain_op    = CELL_HOLD;
		chain_in    = SW_OPEN;

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					out_valid_d = 1'b1;
					out_event_d = EV_NONE;
					if (din.operation) begin
						// rearm
						chain_op = CELL_CLEAR;
						hold_d   = {1'b0, very_long_ticks_q} + 7'd1;
					end else if (s != SW_OPEN) begin
						chain_op = CELL_SHIFT;
						chain_in = s;
						if (hold_q == {1'b0, long_ticks_q}) begin
							out_event_d = base + EV_LONG;
							hold_d      = hold_inc;
						end else if (hold_q == {1'b0, very_long_ticks_q}) begin
							out_event_d = base + EV_VERY_LONG;
							hold_d      = hold_inc;
						end else if (s == taps.newest) begin
							hold_d = hold_inc;
						end
					end else begin
						hold_d = '0;
						if (hold_q > {1'b0, long_ticks_q}) begin
							// release after a long press clears everything
							chain_op = CELL_CLEAR;
						end else if (taps.at_check != SW_OPEN && taps.first_open) begin
							// start a click scan; result goes out when it ends
							out_valid_d = out_valid_q && !dout.ready;
							state_d     = ST_SCAN;
							cnt_d       = '0;
							armed_d     = 1'b0;
							clicks_d    = '0;
							which_d     = taps.at_check;
						end else begin
							chain_op = CELL_SHIFT;
						end
					end
				end
			end

			ST_SCAN: begin
				// one pair per rotation step while the pair lies inside the row
				chain_op = CELL_ROTATE;
				if (32'(cnt_q) <= LAST_PAIR) begin
					if (!armed_q && taps.prev == SW_OPEN && taps.cur == which_q) begin
						armed_d = 1'b1;
					end else if (armed_q && taps.prev == which_q && taps.cur == SW_OPEN) begin
						armed_d = 1'b0;
						if (clicks_q != CLICK_SAT) clicks_d = clicks_q + 3'd1;
					end
				end
				cnt_d = cnt_q + 1'b1;
				if (32'(cnt_q) == HISTORY_DEPTH - 1) state_d = ST_DONE;
			end

			ST_DONE: begin
				if (out_free) begin
					chain_op    = (clicks_q != '0) ? CELL_CLEAR : CELL_SHIFT;
					out_valid_d = 1'b1;
					if (clicks_q != '0 && clicks_q != CLICK_SAT) begin
						out_event_d = EVENT_W'(clicks_q)
							+ ((which_q == SW_USER) ? EV_USER_OFS : EV_NONE);
					end else begin
						out_event_d = EV_NONE;
					end
					state_d = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	assign dout.valid         = out_valid_q;
	assign dout.gesture_event = out_event_q;

	// Scan never runs past one full rotation
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> 32'(cnt_q) < HISTORY_DEPTH)
		else $error("scan counter past row length");

	// Finished scan always hands a word to the output and returns to idle
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("scan result not delivered");

	// Only defined event codes leave the block
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_event_q <= EV_MAX)
		else $error("event code out of range");

	// Click count saturates
	a_click_sat: assert property (@(posedge clk) disable iff (!arst_n)
		clicks_q <= CLICK_SAT)
		else $error("click count overflow");

endmodule
